// ----- src/qef_pkg.sv -----
package qef_pkg;

  localparam int unsigned ENERGY_W        = 37;
  localparam int unsigned WINDOW_LEN_W    = 7;
  localparam int unsigned CFG_INDEX_W     = 1;
  localparam int unsigned CFG_DATA_W      = 37;
  localparam int unsigned DERIV_W         = 16;
  localparam int unsigned WINDOW_MAX_DEF  = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam logic [WINDOW_LEN_W-1:0] WINDOW_LEN_RST = 7'd14;
  localparam logic [ENERGY_W-1:0]     THRESH_RST     = '0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WINDOW_LEN = 1'b0,
    CFG_THRESH     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic first_sq;
    logic first_emit;
    logic emit;
    logic use_c;
  } qef_ctl_t;

endpackage

// ----- src/qef_cell.sv -----
module qef_cell #(
  parameter int unsigned DATA_W   = 37,
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic              clk_i,
  input  logic              shift_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic [IDX_W-1:0]  sel_i,
  output logic [DATA_W-1:0] data_o,
  output logic [DATA_W-1:0] tap_o
);

  logic [DATA_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;
  assign tap_o  = (sel_i == IDX_W'(CELL_IDX)) ? data_q : '0;

endmodule

// ----- src/qef_front.sv -----
module qef_front #(
  parameter int unsigned WINDOW_MAX  = qef_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = qef_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned TAP_W       = 6
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [qef_pkg::WINDOW_LEN_W-1:0]      window_len_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]         sample_i,
  input  logic                                  record_start_i,
  input  logic                                  ready_i,
  output logic                                  valid_o,
  output logic [2*SAMPLE_BITS-2:0]              sq_o,
  output logic signed [qef_pkg::DERIV_W-1:0]    deriv_o,
  output qef_pkg::qef_ctl_t                     ctl_o,
  output logic [TAP_W-1:0]                      tap_o
);

  import qef_pkg::*;

  localparam int unsigned FillW   = $clog2(WINDOW_MAX + 4);
  localparam int unsigned CmpW    = ((FillW > WINDOW_LEN_W) ? FillW : WINDOW_LEN_W) + 1;
  localparam int unsigned SqW     = 2 * SAMPLE_BITS - 1;
  localparam int unsigned XW      = ((SAMPLE_BITS > DERIV_W) ? SAMPLE_BITS : DERIV_W) + 1;
  localparam logic [FillW-1:0] FillMax = FillW'(WINDOW_MAX + 3);
  localparam logic [FillW-1:0] FillSq  = FillW'(3);
  localparam logic signed [XW-1:0] DMax = XW'(32767);
  localparam logic signed [XW-1:0] DMin = -XW'(32768);

  logic signed [SAMPLE_BITS-1:0] hist_q [3];
  logic [FillW-1:0]              fill_q;
  logic                          emitted_q;

  logic                          va_q, vb_q;
  logic signed [SAMPLE_BITS-1:0] d_a_q;
  qef_ctl_t                      ctl_a_q, ctl_b_q;
  logic [TAP_W-1:0]              tap_a_q, tap_b_q;
  logic [SqW-1:0]                sq_b_q;
  logic signed [DERIV_W-1:0]     deriv_b_q;

  logic                          rdy_a, rdy_b, accept;
  logic [FillW-1:0]              fill_eff;
  logic signed [SAMPLE_BITS-1:0] hist2_eff;
  logic                          emitted_eff, square, emit;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [SAMPLE_BITS-1:0] d_new;
  logic [CmpW-1:0]               wl_x, n_x, nm2_x;
  logic signed [XW-1:0]          d_x;
  logic signed [2*SAMPLE_BITS-1:0] prod;

  assign rdy_b      = !vb_q || ready_i;
  assign rdy_a      = !va_q || rdy_b;
  assign in_stall_o = !rdy_a;
  assign accept     = in_valid_i && rdy_a;

  always_comb begin
    fill_eff    = record_start_i ? '0 : fill_q;
    hist2_eff   = record_start_i ? '0 : hist_q[2];
    emitted_eff = record_start_i ? 1'b0 : emitted_q;
    square      = (fill_eff >= FillSq);
    diff        = {sample_i[SAMPLE_BITS-1], sample_i} - {hist2_eff[SAMPLE_BITS-1], hist2_eff};
    d_new       = diff[SAMPLE_BITS:1];
    wl_x        = CmpW'(window_len_i);
    if (wl_x == '0) begin
      n_x = CmpW'(1);
    end else if (wl_x > CmpW'(WINDOW_MAX)) begin
      n_x = CmpW'(WINDOW_MAX);
    end else begin
      n_x = wl_x;
    end
    nm2_x = n_x - CmpW'(2);
    emit  = (CmpW'(fill_eff) >= (n_x + CmpW'(2)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q[0] <= '0;
      hist_q[1] <= '0;
      hist_q[2] <= '0;
      fill_q    <= '0;
      emitted_q <= 1'b0;
    end else if (accept) begin
      hist_q[0] <= sample_i;
      hist_q[1] <= record_start_i ? '0 : hist_q[0];
      hist_q[2] <= record_start_i ? '0 : hist_q[1];
      fill_q    <= (fill_eff < FillMax) ? fill_eff + FillW'(1) : fill_eff;
      emitted_q <= emitted_eff || (square && emit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= accept && square;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && square && rdy_a) begin
      d_a_q              <= d_new;
      ctl_a_q.first_sq   <= (fill_eff == FillSq);
      ctl_a_q.first_emit <= emit && !emitted_eff;
      ctl_a_q.emit       <= emit;
      ctl_a_q.use_c      <= (n_x == CmpW'(1));
      tap_a_q            <= nm2_x[TAP_W-1:0];
    end
  end

  always_comb begin
    d_x  = {{(XW-SAMPLE_BITS){d_a_q[SAMPLE_BITS-1]}}, d_a_q};
    prod = d_a_q * d_a_q;
  end

  always_ff @(posedge clk_i) begin
    if (va_q && rdy_b) begin
      sq_b_q  <= prod[SqW-1:0];
      ctl_b_q <= ctl_a_q;
      tap_b_q <= tap_a_q;
      if (d_x > DMax) begin
        deriv_b_q <= 16'sh7fff;
      end else if (d_x < DMin) begin
        deriv_b_q <= 16'sh8000;
      end else begin
        deriv_b_q <= d_x[DERIV_W-1:0];
      end
    end
  end

  assign valid_o = vb_q;
  assign sq_o    = sq_b_q;
  assign deriv_o = deriv_b_q;
  assign ctl_o   = ctl_b_q;
  assign tap_o   = tap_b_q;

endmodule

// ----- src/qrs_energy_front_end_top.sv -----
// QRS energy front end. Takes one filtered ECG sample per cycle while out_stall_i is low;
// for each sample that fills its window it returns its derivative and the energy summed
// over the last window_len squared derivatives, gated by the cut threshold. A record needs
// window_len + 3 samples before its first word appears. Energy comes from a running
// cumulative sum and a row of WINDOW_MAX-1 cells holding past cumulative values; the cells
// shift once per square, so sustained throughput is one sample per cycle with no stall of
// its own. Configuration writes are only allowed while no sample is in flight.
module qrs_energy_front_end_top #(
  parameter int unsigned WINDOW_MAX  = qef_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = qef_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [qef_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [qef_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic                                record_start_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [qef_pkg::DERIV_W-1:0]  derivative_value_o,
  output logic [qef_pkg::ENERGY_W-1:0]        window_energy_o,
  output logic [qef_pkg::ENERGY_W-1:0]        gated_energy_o,
  output logic                                above_cut_o,
  output logic                                region_start_o
);

  import qef_pkg::*;

  localparam int unsigned NumCells = WINDOW_MAX - 1;
  localparam int unsigned TapW     = (WINDOW_MAX > 2) ? $clog2(WINDOW_MAX - 1) : 1;
  localparam int unsigned SqW      = 2 * SAMPLE_BITS - 1;
  localparam int unsigned CumW     = 2 * SAMPLE_BITS - 1 + $clog2(WINDOW_MAX);
  localparam int unsigned SumW     = (CumW > ENERGY_W) ? CumW : ENERGY_W;
  localparam logic [ENERGY_W-1:0] EnergyMax = {ENERGY_W{1'b1}};

  logic [WINDOW_LEN_W-1:0] window_len_q;
  logic [ENERGY_W-1:0]     thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= WINDOW_LEN_RST;
      thresh_q     <= THRESH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WINDOW_LEN: window_len_q <= cfg_wdata_i[WINDOW_LEN_W-1:0];
        CFG_THRESH:     thresh_q     <= cfg_wdata_i[ENERGY_W-1:0];
        default: ;
      endcase
    end
  end

  logic                      vb, rdy_c, load_c;
  logic [SqW-1:0]            sq_b;
  logic signed [DERIV_W-1:0] deriv_b;
  qef_ctl_t                  ctl_b;
  logic [TapW-1:0]           tap_b;

  qef_front #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS),
    .TAP_W       (TapW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .window_len_i   (window_len_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .record_start_i (record_start_i),
    .ready_i        (rdy_c),
    .valid_o        (vb),
    .sq_o           (sq_b),
    .deriv_o        (deriv_b),
    .ctl_o          (ctl_b),
    .tap_o          (tap_b)
  );

  logic [CumW-1:0] cum_q, cum_base, cum_new, tap_or, tap_sel;
  logic [CumW-1:0] cell_val [NumCells];
  logic [CumW-1:0] cell_tap [NumCells];

  assign cum_base = ctl_b.first_sq ? '0 : cum_q;
  assign cum_new  = cum_base + CumW'(sq_b);

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    qef_cell #(
      .DATA_W   (CumW),
      .IDX_W    (TapW),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (load_c),
      .data_i  ((i == 0) ? cum_base : cell_val[(i == 0) ? 0 : i - 1]),
      .sel_i   (tap_b),
      .data_o  (cell_val[i]),
      .tap_o   (cell_tap[i])
    );
  end

  always_comb begin
    tap_or = '0;
    for (int i = 0; i < NumCells; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
    tap_sel = ctl_b.use_c ? cum_base : tap_or;
  end

  logic                      vc_q, vd_q, ve_q, rdy_d, rdy_e;
  logic [CumW-1:0]           cum_c_q, tap_c_q;
  logic signed [DERIV_W-1:0] deriv_c_q, deriv_d_q, deriv_e_q;
  qef_ctl_t                  ctl_c_q;
  logic                      first_emit_d_q;
  logic [ENERGY_W-1:0]       energy_d_q, energy_e_q, gated_e_q, energy_sat, gated_new;
  logic                      above_e_q, region_e_q, prev_above_q, above_new;
  logic [CumW-1:0]           win;
  logic [SumW-1:0]           win_ext;

  assign rdy_e  = !ve_q || !out_stall_i;
  assign rdy_d  = !vd_q || rdy_e;
  assign rdy_c  = !vc_q || rdy_d;
  assign load_c = vb && rdy_c;

  always_comb begin
    win        = cum_c_q - tap_c_q;
    win_ext    = SumW'(win);
    energy_sat = (win_ext > SumW'(EnergyMax)) ? EnergyMax : win_ext[ENERGY_W-1:0];
    above_new  = (energy_d_q >= thresh_q);
    gated_new  = above_new ? energy_d_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cum_q        <= '0;
      vc_q         <= 1'b0;
      vd_q         <= 1'b0;
      ve_q         <= 1'b0;
      prev_above_q <= 1'b0;
    end else begin
      if (load_c) begin
        cum_q <= cum_new;
      end
      if (rdy_c) begin
        vc_q <= vb;
      end
      if (rdy_d) begin
        vd_q <= vc_q && ctl_c_q.emit;
      end
      if (rdy_e) begin
        ve_q <= vd_q;
      end
      if (vd_q && rdy_e) begin
        prev_above_q <= above_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_c) begin
      cum_c_q   <= cum_new;
      tap_c_q   <= tap_sel;
      deriv_c_q <= deriv_b;
      ctl_c_q   <= ctl_b;
    end
    if (vc_q && rdy_d) begin
      energy_d_q     <= energy_sat;
      deriv_d_q      <= deriv_c_q;
      first_emit_d_q <= ctl_c_q.first_emit;
    end
    if (vd_q && rdy_e) begin
      energy_e_q <= energy_d_q;
      gated_e_q  <= gated_new;
      deriv_e_q  <= deriv_d_q;
      above_e_q  <= above_new;
      region_e_q <= above_new && (first_emit_d_q || !prev_above_q);
    end
  end

  assign out_valid_o        = ve_q;
  assign derivative_value_o = deriv_e_q;
  assign window_energy_o    = energy_e_q;
  assign gated_energy_o     = gated_e_q;
  assign above_cut_o        = above_e_q;
  assign region_start_o     = region_e_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (above_cut_o ? (gated_energy_o == window_energy_o)
                                 : (gated_energy_o == '0)))
    else $error("gated energy disagrees with above_cut");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && region_start_o) |-> above_cut_o)
    else $error("region start without above_cut");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vd_q && !ve_q) |=> out_valid_o)
    else $error("ready word failed to reach the output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vb && load_c && ctl_b.first_sq) |=> (cum_q == CumW'($past(sq_b))))
    else $error("cumulative sum not restarted on first square of a record");

endmodule

// ----- dv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qef_pkg::*;

  localparam logic [ENERGY_W-1:0] ENERGY_TOP    = '1;
  localparam int unsigned         SETTLE_CYCLES = 10;
  localparam int unsigned         PHASE_WORDS   = 78;

  typedef struct {
    logic signed [DERIV_W-1:0] deriv;
    logic [ENERGY_W-1:0]       energy;
    logic [ENERGY_W-1:0]       gated;
    logic                      above;
    logic                      rstart;
  } energy_word_t;

  logic                               clk_i          = 1'b0;
  logic                               rst_ni         = 1'b0;
  logic                               cfg_we_i       = 1'b0;
  logic [CFG_INDEX_W-1:0]             cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0]              cfg_wdata_i    = '0;
  logic                               in_valid_i     = 1'b0;
  logic                               in_stall_o;
  logic signed [SAMPLE_BITS_DEF-1:0]  sample_i       = '0;
  logic                               record_start_i = 1'b0;
  logic                               out_valid_o;
  logic                               out_stall_i    = 1'b0;
  logic signed [DERIV_W-1:0]          derivative_value_o;
  logic [ENERGY_W-1:0]                window_energy_o;
  logic [ENERGY_W-1:0]                gated_energy_o;
  logic                               above_cut_o;
  logic                               region_start_o;

  logic [WINDOW_LEN_W-1:0] win_len_r = WINDOW_LEN_RST;
  logic [ENERGY_W-1:0]     cut_r     = THRESH_RST;
  longint                  hist [3];
  int unsigned             hist_cnt;
  longint                  squares_q [$];
  bit                      prev_above;
  energy_word_t            energy_q [$];
  int unsigned             mismatch_cnt;
  int unsigned             stall_left;
  bit                      tx_idle_on;
  bit                      rx_idle_on;

  qrs_energy_front_end_top u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pause_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic int unsigned eff_window();
    if (win_len_r == 0) return 1;
    if (win_len_r > WINDOW_MAX_DEF) return WINDOW_MAX_DEF;
    return 32'(win_len_r);
  endfunction

  function automatic void clear_record();
    hist = '{0, 0, 0};
    hist_cnt = 0;
    squares_q.delete();
    prev_above = 1'b0;
  endfunction

  function automatic void predict_energy(logic signed [SAMPLE_BITS_DEF-1:0] x, logic rstart);
    longint       diff;
    longint       d;
    longint       total;
    int unsigned  n;
    energy_word_t w;
    if (rstart) clear_record();
    if (hist_cnt == 3) begin
      diff = longint'(x) - hist[2];
      d = diff >>> 1;
      squares_q = {squares_q, d * d};
      if (squares_q.size() > WINDOW_MAX_DEF) void'(squares_q.pop_front());
      n = eff_window();
      if (squares_q.size() >= n) begin
        total = 0;
        for (int k = 0; k < n; k++) total += squares_q[squares_q.size() - 1 - k];
        if (total > longint'(ENERGY_TOP)) total = longint'(ENERGY_TOP);
        w.deriv  = DERIV_W'(d);
        w.energy = ENERGY_W'(total);
        w.above  = (w.energy >= cut_r);
        w.gated  = w.above ? w.energy : '0;
        w.rstart = w.above && !prev_above;
        prev_above = w.above;
        energy_q = {energy_q, w};
      end
    end
    hist[2] = hist[1];
    hist[1] = hist[0];
    hist[0] = longint'(x);
    if (hist_cnt < 3) hist_cnt++;
  endfunction

  task automatic send_sample(logic signed [SAMPLE_BITS_DEF-1:0] x, logic rstart);
    int unsigned gap;
    gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? pause_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_i       <= x;
    record_start_i <= rstart;
    do @(posedge clk_i); while (in_stall_o);
    predict_energy(x, rstart);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (energy_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(logic [WINDOW_LEN_W-1:0] win, logic [ENERGY_W-1:0] cut);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_WINDOW_LEN;
    cfg_wdata_i <= CFG_DATA_W'(win);
    @(posedge clk_i);
    cfg_index_i <= CFG_THRESH;
    cfg_wdata_i <= CFG_DATA_W'(cut);
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    win_len_r = win;
    cut_r     = cut;
  endtask

  task automatic test_reset_defaults();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int i = 0; i < 40; i++) send_sample(SAMPLE_BITS_DEF'($urandom), 1'b0);
  endtask

  task automatic test_derivative_extremes();
    logic signed [SAMPLE_BITS_DEF-1:0] seq [8] = '{16'sh8000, 16'sh0000, 16'shFFFF,
      16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh0001};
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    configure(7'd1, '0);
    foreach (seq[i]) send_sample(seq[i], i == 0);
  endtask

  task automatic test_cut_and_regions();
    logic signed [SAMPLE_BITS_DEF-1:0] seq [11] = '{16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd4096, 16'sd4096, 16'sd4096, 16'sd4096, 16'sd0, 16'sd6144, 16'sd6143};
    configure(7'd1, ENERGY_W'(1) << 20);
    foreach (seq[i]) send_sample(seq[i], i == 0);
  endtask

  task automatic test_record_restart();
    tx_idle_on = 1'b0;
    configure(7'd2, ENERGY_W'(1) << 12);
    for (int i = 0; i < 9; i++) send_sample(SAMPLE_BITS_DEF'($urandom), i == 0 || i == 5);
    configure(7'd0, ENERGY_W'(1) << 12);
    for (int i = 0; i < 3; i++) send_sample(SAMPLE_BITS_DEF'($urandom), 1'b0);
  endtask

  task automatic test_random_stream();
    logic [WINDOW_LEN_W-1:0]           win;
    logic [ENERGY_W-1:0]               cut;
    logic signed [SAMPLE_BITS_DEF-1:0] x;
    int unsigned                       n;
    bit                                burst;
    burst = 1'b0;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: win = 7'd1;
        1: win = 7'd64;
        2: win = 7'd0;
        3: win = 7'd127;
        4: win = 7'd2;
        default: win = WINDOW_LEN_W'($urandom_range(1, 64));
      endcase
      n = (win == 0) ? 1 : ((win > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : 32'(win));
      if (ph == 0) cut = '0;
      else if (ph == 1) cut = ENERGY_TOP;
      else if ($urandom_range(0, 5) == 0) cut = $urandom_range(0, 1) ? '0 : ENERGY_TOP;
      else cut = ENERGY_W'(longint'(n) * $urandom_range(1 << 16, 1 << 26));
      tx_idle_on = (ph % 3 != 0);
      rx_idle_on = (ph % 4 != 1);
      configure(win, cut);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if ($urandom_range(0, 19) == 0) burst = !burst;
        x = SAMPLE_BITS_DEF'(burst ? $urandom : $urandom_range(0, 1023) - 512);
        send_sample(x, $urandom_range(0, 3 * n + 40) == 0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    energy_word_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (energy_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected word: deriv %0d energy %0d gated %0d above %0b start %0b",
                     derivative_value_o, window_energy_o, gated_energy_o, above_cut_o,
                     region_start_o);
        end else begin
          want = energy_q.pop_front();
          if (derivative_value_o !== want.deriv || window_energy_o !== want.energy ||
              gated_energy_o !== want.gated || above_cut_o !== want.above ||
              region_start_o !== want.rstart) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch (exp/got): deriv %0d/%0d energy %0d/%0d gated %0d/%0d %s",
                       want.deriv, derivative_value_o, want.energy, window_energy_o,
                       want.gated, gated_energy_o,
                       $sformatf("above %0b/%0b start %0b/%0b", want.above, above_cut_o,
                                 want.rstart, region_start_o));
          end
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (rx_idle_on && $urandom_range(0, 3) == 0) stall_left = pause_len();
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    clear_record();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_defaults();
    test_derivative_extremes();
    test_cut_and_regions();
    test_record_restart();
    test_random_stream();
    settle();
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/qef_pkg.sv
src/qef_cell.sv
src/qef_front.sv
src/qrs_energy_front_end_top.sv
dv/testbench.sv
